// ----- rtl/pid_step_with_clamp_reset_core_defines.svh -----
// assertion macros shared by the pid core checker
// no dependencies; included by the checker file
`ifndef PID_STEP_WITH_CLAMP_RESET_CORE_DEFINES_SVH
`define PID_STEP_WITH_CLAMP_RESET_CORE_DEFINES_SVH

// same-cycle implication check
`define PIDC_AST_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pidc check failed");

// next-cycle implication check
`define PIDC_AST_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pidc check failed");

`endif

// ----- rtl/pidc_pkg.sv -----
// shared constants and types for the pid step core
// no dependencies; used by pidc_div and pid_step_with_clamp_reset_core
package pidc_pkg;

  // register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW    = 3'd4;

  // reset bounds, +200.0 and -200.0 in q16.16
  localparam logic [31:0] RESET_OUT_HIGH = 32'sd13107200;
  localparam logic [31:0] RESET_OUT_LOW  = -32'sd13107200;

  // integral saturation limits, 48 bit signed
  localparam logic [47:0] INTEG_MAX = {1'b0, {47{1'b1}}};
  localparam logic [47:0] INTEG_MIN = {1'b1, {47{1'b0}}};

  // derivative magnitude limit, 2^62
  localparam logic [63:0] DERIV_LIM = 64'h4000_0000_0000_0000;

  // serial divider geometry
  localparam int unsigned DIV_NUM_W  = 64;
  localparam int unsigned DIV_DEN_W  = 16;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_ITERS  = DIV_NUM_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_ITERS);

  // divider result as seen by the sequencer
  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } pidc_div_res_t;

endpackage

// ----- rtl/pidc_div.sv -----
// unsigned restoring divider, two quotient bits per cycle
// depends on pidc_pkg
module pidc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [pidc_pkg::DIV_NUM_W-1:0]    dividend,
  input  logic [pidc_pkg::DIV_DEN_W-1:0]    divisor,
  output pidc_pkg::pidc_div_res_t           res
);

  logic [pidc_pkg::DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [pidc_pkg::DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [pidc_pkg::DIV_DEN_W-1:0] den_r;
  logic [pidc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;

  // two restoring steps per cycle
  always_comb begin
    logic [pidc_pkg::DIV_DEN_W:0] trial;
    logic                         qbit;
    trial    = '0;
    qbit     = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      for (int k = 0; k < pidc_pkg::DIV_STEPS; k++) begin
        trial = {rem_nxt, quo_nxt[pidc_pkg::DIV_NUM_W-1]};
        qbit  = (trial >= {1'b0, den_r});
        if (qbit) begin
          trial = trial - {1'b0, den_r};
        end
        rem_nxt = trial[pidc_pkg::DIV_DEN_W-1:0];
        quo_nxt = {quo_nxt[pidc_pkg::DIV_NUM_W-2:0], qbit};
      end
      cnt_nxt = cnt_r + pidc_pkg::DIV_CNT_W'(1);
      if (cnt_r == pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_ITERS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;

endmodule

// ----- rtl/pid_step_with_clamp_reset_core.sv -----
// pid control step with output clamp and anti-windup integral clear
// depends on pidc_pkg and pidc_div
//
// Usage:
//   input channel (in_valid / in_stall) carries one request: action,
//   setpoint, measured, time_step. action 1 clears the integral and the
//   last error and returns drive 0, clamped 0.
//   result channel (out_valid / out_stall) returns drive and clamped, one
//   result per request, in order.
//   configuration channel (cfg_valid / cfg_ready, always ready) writes the
//   gains and bounds; write only while the block is idle.
// Sequence and throughput:
//   a control step runs five multiplier passes (33x33, shared), a divide of
//   the derivative product by time_step at two quotient bits per cycle
//   (skipped with time_step 0), then sum and clamp. a clear skips straight
//   to the result. in_stall is high while a request runs.
// Reset: gains 0, bounds +-200.0, integral and last error 0, no result.
// Stall: a result waits in the output register while out_stall is high; the
//   next request may be accepted meanwhile but cannot finish until it drains.
module pid_step_with_clamp_reset_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic signed [31:0]                in_setpoint,
  input  logic signed [31:0]                in_measured,
  input  logic [15:0]                       in_time_step,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                out_drive,
  output logic                              out_clamped,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_KI   = 4'd1;
  localparam logic [3:0] S_MUL_KP   = 4'd2;
  localparam logic [3:0] S_MUL_AH   = 4'd3;
  localparam logic [3:0] S_MUL_AL   = 4'd4;
  localparam logic [3:0] S_MUL_KD   = 4'd5;
  localparam logic [3:0] S_INTEG    = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_SUM      = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]  state_r, state_nxt;

  // configuration registers
  logic [31:0] kp_r, ki_r, kd_r, high_r, low_r;

  // controller state
  logic [47:0] integ_r, integ_nxt;
  logic [31:0] last_err_r, last_err_nxt;

  // per-request working registers
  logic        clr_r, clr_nxt;
  logic [31:0] err_r, err_nxt;
  logic [15:0] dt_r, dt_nxt;
  logic [47:0] acc_a_r, acc_a_nxt;
  logic [47:0] prop_r, prop_nxt;
  logic [63:0] inc_acc_r, inc_acc_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] deriv_r, deriv_nxt;
  logic [64:0] sum_r, sum_nxt;
  logic [63:0] prod_r;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] drive_r, drive_nxt;
  logic        clamped_r, clamped_nxt;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;

  // divider hookup
  logic                     div_start;
  logic [63:0]              div_num;
  pidc_pkg::pidc_div_res_t  div_res;

  logic        in_acc;
  logic        out_free;
  logic [32:0] err_diff;
  logic [32:0] d_err;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign err_diff  = {in_setpoint[31], in_setpoint} - {in_measured[31], in_measured};
  assign d_err     = {err_r[31], err_r} - {last_err_r[31], last_err_r};

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL_KI: begin
        mul_a = {err_r[31], err_r};
        mul_b = {ki_r[31], ki_r};
      end
      S_MUL_KP: begin
        mul_a = {err_r[31], err_r};
        mul_b = {kp_r[31], kp_r};
      end
      S_MUL_AH: begin
        mul_a = {acc_a_r[47], acc_a_r[47:16]};
        mul_b = {17'd0, dt_r};
      end
      S_MUL_AL: begin
        mul_a = {17'd0, acc_a_r[15:0]};
        mul_b = {17'd0, dt_r};
      end
      S_MUL_KD: begin
        mul_a = d_err;
        mul_b = {kd_r[31], kd_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // abs of derivative product feeds the divider
  assign div_num   = prod_r[63] ? (~prod_r + 64'd1) : prod_r;
  assign div_start = (state_r == S_INTEG) && (dt_r != '0);

  pidc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (dt_r),
    .res      (div_res)
  );

  // sequencer and datapath next state
  always_comb begin
    logic [48:0] isum;
    logic [47:0] inc;
    logic [63:0] qlim;
    state_nxt     = state_r;
    integ_nxt     = integ_r;
    last_err_nxt  = last_err_r;
    clr_nxt       = clr_r;
    err_nxt       = err_r;
    dt_nxt        = dt_r;
    acc_a_nxt     = acc_a_r;
    prop_nxt      = prop_r;
    inc_acc_nxt   = inc_acc_r;
    neg_nxt       = neg_r;
    deriv_nxt     = deriv_r;
    sum_nxt       = sum_r;
    drive_nxt     = drive_r;
    clamped_nxt   = clamped_r;
    out_valid_nxt = out_valid_r && out_stall;
    inc           = inc_acc_r[63:16];
    isum          = {integ_r[47], integ_r} + {inc[47], inc};
    qlim          = (div_res.quo > pidc_pkg::DERIV_LIM) ? pidc_pkg::DERIV_LIM : div_res.quo;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          clr_nxt = in_action;
          dt_nxt  = in_time_step;
          // saturate the error to 32 bits
          if (err_diff[32] != err_diff[31]) begin
            err_nxt = err_diff[32] ? 32'h8000_0000 : 32'h7fff_ffff;
          end else begin
            err_nxt = err_diff[31:0];
          end
          state_nxt = in_action ? S_DONE : S_MUL_KI;
        end
      end
      S_MUL_KI: state_nxt = S_MUL_KP;
      S_MUL_KP: begin
        // floor(err*ki / 2^16)
        acc_a_nxt = prod_r[63:16];
        state_nxt = S_MUL_AH;
      end
      S_MUL_AH: begin
        // floor(kp*err / 2^16)
        prop_nxt  = prod_r[63:16];
        state_nxt = S_MUL_AL;
      end
      S_MUL_AL: begin
        // upper half of a*dt, weighted by 2^16
        inc_acc_nxt = {prod_r[47:0], 16'd0};
        state_nxt   = S_MUL_KD;
      end
      S_MUL_KD: begin
        inc_acc_nxt = inc_acc_r + prod_r;
        state_nxt   = S_INTEG;
      end
      S_INTEG: begin
        // integral update with 48 bit saturation
        if (isum[48] != isum[47]) begin
          integ_nxt = isum[48] ? pidc_pkg::INTEG_MIN : pidc_pkg::INTEG_MAX;
        end else begin
          integ_nxt = isum[47:0];
        end
        neg_nxt = prod_r[63];
        if (dt_r == '0) begin
          deriv_nxt = '0;
          state_nxt = S_SUM;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          deriv_nxt = neg_r ? (~qlim + 64'd1) : qlim;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt   = {{17{prop_r[47]}}, prop_r} + {{17{integ_r[47]}}, integ_r}
                  + {deriv_r[63], deriv_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // finish once the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (clr_r) begin
            drive_nxt    = '0;
            clamped_nxt  = 1'b0;
            integ_nxt    = '0;
            last_err_nxt = '0;
          end else begin
            last_err_nxt = err_r;
            if ($signed(sum_r) > $signed({{33{high_r[31]}}, high_r})) begin
              drive_nxt   = high_r;
              clamped_nxt = 1'b1;
              integ_nxt   = '0;
            end else if ($signed(sum_r) < $signed({{33{low_r[31]}}, low_r})) begin
              drive_nxt   = low_r;
              clamped_nxt = 1'b1;
              integ_nxt   = '0;
            end else begin
              drive_nxt   = sum_r[31:0];
              clamped_nxt = 1'b0;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      last_err_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      last_err_r  <= last_err_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      high_r <= pidc_pkg::RESET_OUT_HIGH;
      low_r  <= pidc_pkg::RESET_OUT_LOW;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pidc_pkg::REG_PROP_GAIN:  kp_r   <= cfg_data;
        pidc_pkg::REG_INTEG_GAIN: ki_r   <= cfg_data;
        pidc_pkg::REG_DERIV_GAIN: kd_r   <= cfg_data;
        pidc_pkg::REG_OUT_HIGH:   high_r <= cfg_data;
        pidc_pkg::REG_OUT_LOW:    low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    clr_r     <= clr_nxt;
    err_r     <= err_nxt;
    dt_r      <= dt_nxt;
    acc_a_r   <= acc_a_nxt;
    prop_r    <= prop_nxt;
    inc_acc_r <= inc_acc_nxt;
    neg_r     <= neg_nxt;
    deriv_r   <= deriv_nxt;
    sum_r     <= sum_nxt;
    drive_r   <= drive_nxt;
    clamped_r <= clamped_nxt;
    prod_r    <= mul_full[63:0];
  end

  assign out_valid   = out_valid_r;
  assign out_drive   = drive_r;
  assign out_clamped = clamped_r;

endmodule

// ----- rtl/pidc_chk.sv -----
// port-level checker for the pid step core, bound to the top level
// depends on pid_step_with_clamp_reset_core_defines.svh
`include "pid_step_with_clamp_reset_core_defines.svh"

module pidc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_drive,
  input logic        out_clamped
);

  logic       in_acc, out_acc;
  logic [1:0] outst_r, outst_nxt;
  logic       clr_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // requests accepted but not yet answered
  always_comb begin
    outst_nxt = outst_r;
    if (in_acc && !out_acc) begin
      outst_nxt = outst_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      outst_nxt = outst_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outst_r <= '0;
      clr_r   <= 1'b0;
    end else begin
      outst_r <= outst_nxt;
      if (in_acc) begin
        clr_r <= in_action;
      end
    end
  end

  // a stalled result holds
  `PIDC_AST_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_drive) && $stable(out_clamped))

  // the block is busy right after taking a request
  `PIDC_AST_NXT(a_busy_after_req, clk, rst_n, in_acc, in_stall)

  // no result without a pending request
  `PIDC_AST_NOW(a_no_spurious, clk, rst_n, out_valid, outst_r != 2'd0)

  // a clear request answers zero, not clamped
  `PIDC_AST_NOW(a_clear_zero, clk, rst_n, out_valid && (outst_r == 2'd1) && clr_r, (out_drive == 32'd0) && !out_clamped)

endmodule

bind pid_step_with_clamp_reset_core pidc_chk u_pidc_chk (.*);
